FILE: rtl/stopwatch_countdown_timer_controller_macros.svh
// Assertion macros for the stopwatch and countdown timer controller.
`ifndef STOPWATCH_COUNTDOWN_TIMER_CONTROLLER_MACROS_SVH
`define STOPWATCH_COUNTDOWN_TIMER_CONTROLLER_MACROS_SVH

// same-cycle implication
`define SWCT_ASSERT_IMP(name, pre, post, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

// next-cycle implication
`define SWCT_ASSERT_NXT(name, pre, post, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

FILE: rtl/swct_pkg.sv
// Shared types and constants for the stopwatch and countdown timer controller.
package swct_pkg;

    localparam int SW_BITS     = 32;
    localparam int REM_BITS    = 27;
    localparam int DUR_BITS    = 17;
    localparam int SECS_BITS   = 17;
    localparam int RATE_BITS   = 10;
    localparam int WELC_BITS   = 16;
    localparam int DVD_BITS    = 28;
    localparam int DVS_BITS    = 12;
    localparam int DIV_STEPS   = DVD_BITS;
    localparam int DIV_CNT_W   = $clog2(DIV_STEPS);

    // duration split: hours and minutes by reciprocal multiply
    localparam int REST_BITS   = 12;
    localparam int HR_PROD_W   = DUR_BITS + 16;
    localparam int MN_PROD_W   = REST_BITS + 13;
    localparam int HR_SHIFT    = 27;
    localparam int MN_SHIFT    = 18;
    localparam logic [15:0] HR_RECIP = 16'd37283;
    localparam logic [12:0] MN_RECIP = 13'd4370;

    localparam logic [DUR_BITS-1:0]  DUR_RESET   = DUR_BITS'(300);
    localparam logic [RATE_BITS-1:0] RATE_RESET  = RATE_BITS'(1000);
    localparam logic [WELC_BITS-1:0] WELC_RESET  = WELC_BITS'(1600);
    localparam logic [REM_BITS-1:0]  REM_RESET   = REM_BITS'(300 * 1000);
    localparam logic [DVS_BITS-1:0]  SECS_PER_HR = DVS_BITS'(3600);
    localparam logic [DVS_BITS-1:0]  SECS_PER_MN = DVS_BITS'(60);

    localparam logic [2:0] KEY_UP    = 3'd0;
    localparam logic [2:0] KEY_DOWN  = 3'd1;
    localparam logic [2:0] KEY_RIGHT = 3'd2;
    localparam logic [2:0] KEY_LEFT  = 3'd3;
    localparam logic [2:0] KEY_OK    = 3'd4;
    localparam logic [2:0] KEY_BACK  = 3'd5;

    localparam logic       MODE_TICK = 1'b0;

    localparam logic [1:0] FLD_HOURS = 2'd0;
    localparam logic [1:0] FLD_MINS  = 2'd1;
    localparam logic [1:0] FLD_SECS  = 2'd2;

    localparam logic       CFG_TPS     = 1'b0;
    localparam logic       CFG_WELCOME = 1'b1;

    typedef enum logic [2:0] {
        SCR_WELCOME = 3'd0,
        SCR_HOME    = 3'd1,
        SCR_WATCH   = 3'd2,
        SCR_TIMER   = 3'd3,
        SCR_EDIT    = 3'd4,
        SCR_DONE    = 3'd5
    } screen_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_EXEC,
        ST_HOURS,
        ST_REST,
        ST_MINS,
        ST_SPLIT,
        ST_ADJ,
        ST_LOAD,
        ST_SECS,
        ST_WAIT_S,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic                start;
        logic [DVD_BITS-1:0] dividend;
        logic [DVS_BITS-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic                busy;
        logic                done;
        logic [DVD_BITS-1:0] quotient;
        logic [DVS_BITS-1:0] remainder;
    } div_rsp_t;

    typedef struct packed {
        logic [2:0]           pad;
        logic                 quit;
        logic                 alarm_stop;
        logic                 alarm_start;
        logic [DUR_BITS-1:0]  duration_seconds;
        logic [SECS_BITS-1:0] remaining_seconds;
        logic                 timer_active;
        logic                 stopwatch_active;
        logic [31:0]          stopwatch_count;
        logic [1:0]           edit_field;
        logic                 selected_row;
        logic [2:0]           screen;
    } out_word_t;

endpackage

FILE: rtl/stopwatch_countdown_timer_controller.sv
// Stopwatch and countdown timer controller: sequencer, state and output register.
// Each accepted word runs through EXEC, the divider (SECS, WAIT_S) and OUT; edit up/down keys
// first split the duration into hours, minutes and seconds, adjust it and reload over six steps.
// One word is worked at a time, through the 28-step divider; s_axis_tready is high only in idle.
// A new word is taken while the previous result still waits on the master side.
// rst_n sets the timer state asynchronously to power-on values, work and output registers aside; no clearing pass.
`include "stopwatch_countdown_timer_controller_macros.svh"

module stopwatch_countdown_timer_controller (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // key[2:0], press_kind[4:3], zero fill
    input  logic        s_axis_tuser,   // mode[0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [79:0] m_axis_tdata,   // screen[2:0], selected_row[3], edit_field[5:4],
                                        // stopwatch_count[37:6], stopwatch_active[38],
                                        // timer_active[39], remaining_seconds[56:40],
                                        // duration_seconds[73:57], alarm_start[74],
                                        // alarm_stop[75], quit[76], zero fill
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data
);

    swct_pkg::state_t                   state_reg, state_next;
    swct_pkg::screen_t                  screen_reg, screen_next;
    logic                               row_reg, row_next;
    logic [1:0]                         field_reg, field_next;
    logic [swct_pkg::WELC_BITS-1:0]     wc_reg, wc_next;
    logic [swct_pkg::SW_BITS-1:0]       sw_reg, sw_next;
    logic                               sw_on_reg, sw_on_next;
    logic [swct_pkg::DUR_BITS-1:0]      dur_reg, dur_next;
    logic [swct_pkg::REM_BITS-1:0]      rem_reg, rem_next;
    logic                               tmr_on_reg, tmr_on_next;
    logic                               quit_reg, quit_next;
    logic [swct_pkg::RATE_BITS-1:0]     tps_reg, tps_next;
    logic [swct_pkg::WELC_BITS-1:0]     welc_reg, welc_next;
    logic                               mode_reg, mode_next;
    logic [2:0]                         key_reg, key_next;
    logic [1:0]                         kind_reg, kind_next;
    logic                               alarm_reg, alarm_next;
    logic                               stop_reg, stop_next;
    logic [4:0]                         hr_reg, hr_next;
    logic [swct_pkg::REST_BITS-1:0]     rest_reg, rest_next;
    logic [5:0]                         min_reg, min_next;
    logic [5:0]                         sec_reg, sec_next;
    logic [swct_pkg::SECS_BITS-1:0]     secs_reg, secs_next;
    logic                               out_valid_reg, out_valid_next;
    swct_pkg::out_word_t                out_word_reg, out_word_next;

    swct_pkg::div_req_t                 div_req;
    swct_pkg::div_rsp_t                 div_rsp;

    logic [swct_pkg::RATE_BITS-1:0]     rate;
    logic [swct_pkg::REM_BITS-1:0]      full_ticks;
    logic                               key_live;
    logic                               adjust_req;
    logic                               out_free;
    logic [swct_pkg::SW_BITS+31:0]      sw_ext;

    // h/m/s split
    logic [swct_pkg::HR_PROD_W-1:0]     hr_prod;
    logic [swct_pkg::MN_PROD_W-1:0]     mn_prod;
    logic [swct_pkg::DUR_BITS-1:0]      rest_full;
    logic [swct_pkg::REST_BITS-1:0]     sec_full;

    // h/m/s edit
    logic [4:0]                         adj_h;
    logic [5:0]                         adj_m;
    logic [5:0]                         adj_s;
    logic [swct_pkg::DUR_BITS-1:0]      adj_dur;

    logic [swct_pkg::WELC_BITS-1:0]     wc_inc;
    logic [swct_pkg::REM_BITS-1:0]      rem_tick;

    swct_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign rate       = (tps_reg == '0) ? swct_pkg::RATE_BITS'(1) : tps_reg;
    assign full_ticks = swct_pkg::REM_BITS'(dur_reg) * swct_pkg::REM_BITS'(rate);
    assign key_live   = (mode_reg != swct_pkg::MODE_TICK) && !kind_reg[1];
    assign adjust_req = key_live && (screen_reg == swct_pkg::SCR_EDIT)
                        && ((key_reg == swct_pkg::KEY_UP) || (key_reg == swct_pkg::KEY_DOWN));
    assign out_free   = !out_valid_reg || m_axis_tready;
    assign sw_ext     = {32'd0, sw_reg};
    assign cfg_ready  = 1'b1;

    // duration is below 24 h, so the reciprocals give exact hours and minutes
    assign hr_prod   = swct_pkg::HR_PROD_W'(dur_reg) * swct_pkg::HR_PROD_W'(swct_pkg::HR_RECIP);
    assign mn_prod   = swct_pkg::MN_PROD_W'(rest_reg) * swct_pkg::MN_PROD_W'(swct_pkg::MN_RECIP);
    assign rest_full = dur_reg - swct_pkg::DUR_BITS'(hr_reg) * swct_pkg::DUR_BITS'(swct_pkg::SECS_PER_HR);
    assign sec_full  = rest_reg
                       - swct_pkg::REST_BITS'(min_reg) * swct_pkg::REST_BITS'(swct_pkg::SECS_PER_MN);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            swct_pkg::ST_IDLE:
                if (s_axis_tvalid)
                    state_next = swct_pkg::ST_EXEC;
            swct_pkg::ST_EXEC:
                state_next = adjust_req ? swct_pkg::ST_HOURS : swct_pkg::ST_SECS;
            swct_pkg::ST_HOURS:
                state_next = swct_pkg::ST_REST;
            swct_pkg::ST_REST:
                state_next = swct_pkg::ST_MINS;
            swct_pkg::ST_MINS:
                state_next = swct_pkg::ST_SPLIT;
            swct_pkg::ST_SPLIT:
                state_next = swct_pkg::ST_ADJ;
            swct_pkg::ST_ADJ:
                state_next = swct_pkg::ST_LOAD;
            swct_pkg::ST_LOAD:
                state_next = swct_pkg::ST_SECS;
            swct_pkg::ST_SECS:
                state_next = swct_pkg::ST_WAIT_S;
            swct_pkg::ST_WAIT_S:
                if (div_rsp.done)
                    state_next = swct_pkg::ST_OUT;
            swct_pkg::ST_OUT:
                if (out_free)
                    state_next = swct_pkg::ST_IDLE;
            default:
                state_next = swct_pkg::ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        s_axis_tready    = 1'b0;
        div_req.start    = 1'b0;
        div_req.dividend = swct_pkg::DVD_BITS'(rem_reg) + swct_pkg::DVD_BITS'(rate)
                           - swct_pkg::DVD_BITS'(1);
        div_req.divisor  = swct_pkg::DVS_BITS'(rate);
        case (state_reg)
            swct_pkg::ST_IDLE:
                s_axis_tready = 1'b1;
            swct_pkg::ST_SECS:
                div_req.start = 1'b1;
            default:
            begin
                s_axis_tready = 1'b0;
            end
        endcase
    end

    // edit arithmetic on the split duration
    always_comb
    begin
        adj_h = hr_reg;
        adj_m = min_reg;
        adj_s = sec_reg;
        case (field_reg)
            swct_pkg::FLD_HOURS:
                if (key_reg == swct_pkg::KEY_UP)
                    adj_h = (hr_reg == 5'd23) ? 5'd0 : hr_reg + 5'd1;
                else
                    adj_h = (hr_reg == 5'd0) ? 5'd23 : hr_reg - 5'd1;
            swct_pkg::FLD_MINS:
                if (key_reg == swct_pkg::KEY_UP)
                    adj_m = (adj_m == 6'd59) ? 6'd0 : adj_m + 6'd1;
                else
                    adj_m = (adj_m == 6'd0) ? 6'd59 : adj_m - 6'd1;
            default:
                if (key_reg == swct_pkg::KEY_UP)
                    adj_s = (adj_s == 6'd59) ? 6'd0 : adj_s + 6'd1;
                else
                    adj_s = (adj_s == 6'd0) ? 6'd59 : adj_s - 6'd1;
        endcase
        adj_dur = swct_pkg::DUR_BITS'(adj_h) * swct_pkg::DUR_BITS'(swct_pkg::SECS_PER_HR)
                  + swct_pkg::DUR_BITS'(adj_m) * swct_pkg::DUR_BITS'(swct_pkg::SECS_PER_MN)
                  + swct_pkg::DUR_BITS'(adj_s);
    end

    assign wc_inc   = (wc_reg == '1) ? wc_reg : wc_reg + 1'b1;
    assign rem_tick = (rem_reg != '0) ? rem_reg - 1'b1 : rem_reg;

    // datapath
    always_comb
    begin
        screen_next    = screen_reg;
        row_next       = row_reg;
        field_next     = field_reg;
        wc_next        = wc_reg;
        sw_next        = sw_reg;
        sw_on_next     = sw_on_reg;
        dur_next       = dur_reg;
        rem_next       = rem_reg;
        tmr_on_next    = tmr_on_reg;
        quit_next      = quit_reg;
        tps_next       = tps_reg;
        welc_next      = welc_reg;
        mode_next      = mode_reg;
        key_next       = key_reg;
        kind_next      = kind_reg;
        alarm_next     = alarm_reg;
        stop_next      = stop_reg;
        hr_next        = hr_reg;
        rest_next      = rest_reg;
        min_next       = min_reg;
        sec_next       = sec_reg;
        secs_next      = secs_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        out_word_next  = out_word_reg;

        if (cfg_valid)
        begin
            if (cfg_index == swct_pkg::CFG_TPS)
                tps_next = cfg_data[swct_pkg::RATE_BITS-1:0];
            else
                welc_next = cfg_data;
        end

        case (state_reg)
            swct_pkg::ST_IDLE:
                if (s_axis_tvalid)
                begin
                    mode_next  = s_axis_tuser;
                    key_next   = s_axis_tdata[2:0];
                    kind_next  = s_axis_tdata[4:3];
                    alarm_next = 1'b0;
                    stop_next  = 1'b0;
                end
            swct_pkg::ST_EXEC:
                if (mode_reg == swct_pkg::MODE_TICK)
                begin
                    if (sw_on_reg)
                        sw_next = sw_reg + swct_pkg::SW_BITS'(1);
                    if (screen_reg == swct_pkg::SCR_WELCOME)
                    begin
                        wc_next = wc_inc;
                        if (wc_inc >= welc_reg)
                            screen_next = swct_pkg::SCR_HOME;
                    end
                    if (tmr_on_reg)
                    begin
                        rem_next = rem_tick;
                        if (rem_tick == '0)
                        begin
                            tmr_on_next = 1'b0;
                            screen_next = swct_pkg::SCR_DONE;
                            alarm_next  = 1'b1;
                        end
                    end
                end
                else if (key_live)
                begin
                    case (screen_reg)
                        swct_pkg::SCR_WELCOME:
                            screen_next = swct_pkg::SCR_HOME;
                        swct_pkg::SCR_DONE:
                            if ((key_reg == swct_pkg::KEY_OK) || (key_reg == swct_pkg::KEY_BACK))
                            begin
                                stop_next   = 1'b1;
                                screen_next = swct_pkg::SCR_TIMER;
                                row_next    = 1'b1;
                            end
                        swct_pkg::SCR_HOME:
                            if (key_reg == swct_pkg::KEY_BACK)
                                quit_next = 1'b1;
                            else if ((key_reg == swct_pkg::KEY_UP)
                                     || (key_reg == swct_pkg::KEY_DOWN))
                                row_next = ~row_reg;
                            else if (key_reg == swct_pkg::KEY_OK)
                            begin
                                screen_next = row_reg ? swct_pkg::SCR_TIMER : swct_pkg::SCR_WATCH;
                                row_next    = 1'b0;
                            end
                        swct_pkg::SCR_WATCH:
                            if (key_reg == swct_pkg::KEY_BACK)
                            begin
                                screen_next = swct_pkg::SCR_HOME;
                                row_next    = 1'b0;
                            end
                            else if (key_reg == swct_pkg::KEY_OK)
                                sw_on_next = ~sw_on_reg;
                            else if (key_reg == swct_pkg::KEY_RIGHT)
                            begin
                                sw_on_next = 1'b0;
                                sw_next    = '0;
                            end
                        swct_pkg::SCR_TIMER:
                            if (key_reg == swct_pkg::KEY_BACK)
                            begin
                                screen_next = swct_pkg::SCR_HOME;
                                row_next    = 1'b1;
                            end
                            else if (key_reg == swct_pkg::KEY_LEFT)
                            begin
                                tmr_on_next = 1'b0;
                                rem_next    = full_ticks;
                            end
                            else if ((key_reg == swct_pkg::KEY_RIGHT) && !tmr_on_reg)
                            begin
                                screen_next = swct_pkg::SCR_EDIT;
                                field_next  = swct_pkg::FLD_HOURS;
                            end
                            else if (key_reg == swct_pkg::KEY_OK)
                            begin
                                if (tmr_on_reg)
                                begin
                                    tmr_on_next = 1'b0;
                                    if (rem_reg == '0)
                                    begin
                                        screen_next = swct_pkg::SCR_DONE;
                                        alarm_next  = 1'b1;
                                    end
                                end
                                else
                                begin
                                    if (rem_reg == '0)
                                        rem_next = full_ticks;
                                    tmr_on_next = 1'b1;
                                end
                            end
                        swct_pkg::SCR_EDIT:
                            if ((key_reg == swct_pkg::KEY_BACK) || (key_reg == swct_pkg::KEY_OK))
                                screen_next = swct_pkg::SCR_TIMER;
                            else if (key_reg == swct_pkg::KEY_LEFT)
                            begin
                                case (field_reg)
                                    swct_pkg::FLD_HOURS: field_next = swct_pkg::FLD_SECS;
                                    swct_pkg::FLD_MINS:  field_next = swct_pkg::FLD_HOURS;
                                    default:             field_next = swct_pkg::FLD_MINS;
                                endcase
                                if (field_reg == 2'd3)
                                    field_next = swct_pkg::FLD_SECS;
                            end
                            else if (key_reg == swct_pkg::KEY_RIGHT)
                            begin
                                case (field_reg)
                                    swct_pkg::FLD_HOURS: field_next = swct_pkg::FLD_MINS;
                                    swct_pkg::FLD_MINS:  field_next = swct_pkg::FLD_SECS;
                                    default:             field_next = swct_pkg::FLD_HOURS;
                                endcase
                                if (field_reg == 2'd3)
                                    field_next = swct_pkg::FLD_MINS;
                            end
                        default:
                            screen_next = screen_reg;
                    endcase
                end
            swct_pkg::ST_HOURS:
                hr_next = hr_prod[swct_pkg::HR_SHIFT +: 5];
            swct_pkg::ST_REST:
                rest_next = rest_full[swct_pkg::REST_BITS-1:0];
            swct_pkg::ST_MINS:
                min_next = mn_prod[swct_pkg::MN_SHIFT +: 6];
            swct_pkg::ST_SPLIT:
                sec_next = sec_full[5:0];
            swct_pkg::ST_ADJ:
                dur_next = (adj_dur == '0) ? swct_pkg::DUR_BITS'(1) : adj_dur;
            swct_pkg::ST_LOAD:
                rem_next = full_ticks;
            swct_pkg::ST_WAIT_S:
                if (div_rsp.done)
                begin
                    if (div_rsp.quotient[swct_pkg::DVD_BITS-1:swct_pkg::SECS_BITS] != '0)
                        secs_next = '1;
                    else
                        secs_next = div_rsp.quotient[swct_pkg::SECS_BITS-1:0];
                end
            swct_pkg::ST_OUT:
                if (out_free)
                begin
                    out_valid_next                  = 1'b1;
                    out_word_next.pad               = '0;
                    out_word_next.quit              = quit_reg;
                    out_word_next.alarm_stop        = stop_reg;
                    out_word_next.alarm_start       = alarm_reg;
                    out_word_next.duration_seconds  = dur_reg;
                    out_word_next.remaining_seconds = secs_reg;
                    out_word_next.timer_active      = tmr_on_reg;
                    out_word_next.stopwatch_active  = sw_on_reg;
                    out_word_next.stopwatch_count   = sw_ext[31:0];
                    out_word_next.edit_field        = field_reg;
                    out_word_next.selected_row      = row_reg;
                    out_word_next.screen            = screen_reg;
                end
            default:
                out_word_next = out_word_reg;
        endcase

        // an expiry empties the countdown
        if (alarm_next && !alarm_reg)
            rem_next = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= swct_pkg::ST_IDLE;
            screen_reg    <= swct_pkg::SCR_WELCOME;
            row_reg       <= 1'b0;
            field_reg     <= swct_pkg::FLD_HOURS;
            wc_reg        <= '0;
            sw_reg        <= '0;
            sw_on_reg     <= 1'b0;
            dur_reg       <= swct_pkg::DUR_RESET;
            rem_reg       <= swct_pkg::REM_RESET;
            tmr_on_reg    <= 1'b0;
            quit_reg      <= 1'b0;
            tps_reg       <= swct_pkg::RATE_RESET;
            welc_reg      <= swct_pkg::WELC_RESET;
            alarm_reg     <= 1'b0;
            stop_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            screen_reg    <= screen_next;
            row_reg       <= row_next;
            field_reg     <= field_next;
            wc_reg        <= wc_next;
            sw_reg        <= sw_next;
            sw_on_reg     <= sw_on_next;
            dur_reg       <= dur_next;
            rem_reg       <= rem_next;
            tmr_on_reg    <= tmr_on_next;
            quit_reg      <= quit_next;
            tps_reg       <= tps_next;
            welc_reg      <= welc_next;
            alarm_reg     <= alarm_next;
            stop_reg      <= stop_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg     <= mode_next;
        key_reg      <= key_next;
        kind_reg     <= kind_next;
        hr_reg       <= hr_next;
        rest_reg     <= rest_next;
        min_reg      <= min_next;
        sec_reg      <= sec_next;
        secs_reg     <= secs_next;
        out_word_reg <= out_word_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_word_reg;

    `SWCT_ASSERT_IMP(a_div_idle, s_axis_tready, !div_rsp.busy, "divider busy while idle")
    `SWCT_ASSERT_NXT(a_one_word, s_axis_tvalid && s_axis_tready, !s_axis_tready, "second word taken during work")
    `SWCT_ASSERT_IMP(a_alarm_done, m_axis_tvalid && out_word_reg.alarm_start, (out_word_reg.screen == swct_pkg::SCR_DONE) && !out_word_reg.timer_active, "alarm without done screen")
    `SWCT_ASSERT_IMP(a_stop_timer, m_axis_tvalid && out_word_reg.alarm_stop, (out_word_reg.screen == swct_pkg::SCR_TIMER) && out_word_reg.selected_row, "stop without timer screen")

endmodule

FILE: rtl/swct_div.sv
// Restoring divider, one quotient bit per cycle.
module swct_div (
    input  logic               clk,
    input  logic               rst_n,
    input  swct_pkg::div_req_t req,
    output swct_pkg::div_rsp_t rsp
);

    logic                               busy_reg, busy_next;
    logic                               done_reg, done_next;
    logic [swct_pkg::DIV_CNT_W-1:0]     cnt_reg, cnt_next;
    logic [swct_pkg::DVD_BITS-1:0]      quo_reg, quo_next;
    logic [swct_pkg::DVS_BITS-1:0]      rem_reg, rem_next;
    logic [swct_pkg::DVS_BITS-1:0]      dvs_reg, dvs_next;
    logic [swct_pkg::DVS_BITS:0]        shifted;
    logic [swct_pkg::DVS_BITS+1:0]      diff;
    logic                               ge;

    assign shifted = {rem_reg, quo_reg[swct_pkg::DVD_BITS-1]};
    assign diff    = {1'b0, shifted} - {2'b00, dvs_reg};
    assign ge      = ~diff[swct_pkg::DVS_BITS+1];

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            quo_next  = req.dividend;
            rem_next  = '0;
            dvs_next  = req.divisor;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? diff[swct_pkg::DVS_BITS-1:0] : shifted[swct_pkg::DVS_BITS-1:0];
            quo_next = {quo_reg[swct_pkg::DVD_BITS-2:0], ge};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == swct_pkg::DIV_CNT_W'(swct_pkg::DIV_STEPS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign rsp.busy      = busy_reg;
    assign rsp.done      = done_reg;
    assign rsp.quotient  = quo_reg;
    assign rsp.remainder = rem_reg;

endmodule

FILE: tb/stopwatch_countdown_timer_controller_test.sv
// Self-checking testbench for the stopwatch and countdown timer controller.
module stopwatch_countdown_timer_controller_test;
    timeunit 1ns;
    timeprecision 1ps;

    import swct_pkg::*;

    localparam logic       MODE_KEY     = 1'b1;
    localparam logic [1:0] PRESS_SHORT  = 2'd0;
    localparam logic [1:0] PRESS_REPEAT = 2'd1;
    localparam logic [1:0] PRESS_OTHER  = 2'd2;
    localparam logic [1:0] PRESS_SPARE  = 2'd3;
    localparam logic [2:0] KEY_SPARE    = 3'd7;
    localparam longint unsigned SECS_MAX = (64'd1 << SECS_BITS) - 1;
    localparam int STALL_LIMIT = 4000;
    localparam int HOLD_CYCLES = 300;
    localparam int HOLD_AT     = 400;

    typedef struct packed {
        logic       mode;
        logic [2:0] key;
        logic [1:0] kind;
    } press_word_t;

    class timer_scoreboard;
        logic [RATE_BITS-1:0] tps;
        logic [WELC_BITS-1:0] welcome_limit;
        screen_t              scr;
        logic                 row;
        logic [1:0]           fld;
        logic [WELC_BITS-1:0] welc_cnt;
        logic [SW_BITS-1:0]   sw_cnt;
        logic                 sw_on;
        logic [DUR_BITS-1:0]  dur;
        logic [REM_BITS-1:0]  rem;
        logic                 tmr_on;
        logic                 quit;
        out_word_t            due_readouts[$];
        int                   errors;

        function new();
            tps           = RATE_RESET;
            welcome_limit = WELC_RESET;
            scr           = SCR_WELCOME;
            row           = 1'b0;
            fld           = FLD_HOURS;
            welc_cnt      = '0;
            sw_cnt        = '0;
            sw_on         = 1'b0;
            dur           = DUR_RESET;
            rem           = full_ticks();
            tmr_on        = 1'b0;
            quit          = 1'b0;
            errors        = 0;
        endfunction

        function void set_reg(logic idx, logic [15:0] val);
            if (idx == CFG_TPS)
                tps = val[RATE_BITS-1:0];
            else
                welcome_limit = val;
        endfunction

        function longint unsigned rate();
            return (tps == 0) ? 64'd1 : 64'(tps);
        endfunction

        function logic [REM_BITS-1:0] full_ticks();
            return REM_BITS'(64'(dur) * rate());
        endfunction

        function void expire(inout logic alarm);
            tmr_on = 1'b0;
            rem    = '0;
            scr    = SCR_DONE;
            alarm  = 1'b1;
        endfunction

        function void adjust(logic up);
            int unsigned h, m, s, d;
            h = (dur / 3600) % 24;
            m = (dur / 60) % 60;
            s = dur % 60;
            case (fld)
                FLD_HOURS: h = up ? (h + 1) % 24 : (h + 23) % 24;
                FLD_MINS:  m = up ? (m + 1) % 60 : (m + 59) % 60;
                default:   s = up ? (s + 1) % 60 : (s + 59) % 60;
            endcase
            d = h * 3600 + m * 60 + s;
            if (d == 0)
                d = 1;
            dur = DUR_BITS'(d);
            rem = full_ticks();
        endfunction

        function void tick(inout logic alarm);
            if (sw_on)
                sw_cnt = sw_cnt + 1'b1;
            if (scr == SCR_WELCOME)
            begin
                if (welc_cnt != '1)
                    welc_cnt = welc_cnt + 1'b1;
                if (welc_cnt >= welcome_limit)
                    scr = SCR_HOME;
            end
            if (tmr_on)
            begin
                if (rem != 0)
                    rem = rem - 1'b1;
                if (rem == 0)
                    expire(alarm);
            end
        endfunction

        function void press(logic [2:0] key, inout logic alarm, inout logic stop);
            case (scr)
                SCR_WELCOME: scr = SCR_HOME;
                SCR_DONE:
                    if (key == KEY_OK || key == KEY_BACK)
                    begin
                        stop = 1'b1;
                        scr  = SCR_TIMER;
                        row  = 1'b1;
                    end
                SCR_HOME:
                    if (key == KEY_BACK)
                        quit = 1'b1;
                    else if (key == KEY_UP || key == KEY_DOWN)
                        row = ~row;
                    else if (key == KEY_OK)
                    begin
                        scr = row ? SCR_TIMER : SCR_WATCH;
                        row = 1'b0;
                    end
                SCR_WATCH:
                    if (key == KEY_BACK)
                    begin
                        scr = SCR_HOME;
                        row = 1'b0;
                    end
                    else if (key == KEY_OK)
                        sw_on = ~sw_on;
                    else if (key == KEY_RIGHT)
                    begin
                        sw_on  = 1'b0;
                        sw_cnt = '0;
                    end
                SCR_TIMER:
                    if (key == KEY_BACK)
                    begin
                        scr = SCR_HOME;
                        row = 1'b1;
                    end
                    else if (key == KEY_LEFT)
                    begin
                        tmr_on = 1'b0;
                        rem    = full_ticks();
                    end
                    else if (key == KEY_RIGHT && !tmr_on)
                    begin
                        scr = SCR_EDIT;
                        fld = FLD_HOURS;
                    end
                    else if (key == KEY_OK)
                    begin
                        if (tmr_on)
                        begin
                            if (rem == 0)
                                expire(alarm);
                            else
                                tmr_on = 1'b0;
                        end
                        else
                        begin
                            if (rem == 0)
                                rem = full_ticks();
                            tmr_on = 1'b1;
                        end
                    end
                SCR_EDIT:
                    if (key == KEY_BACK || key == KEY_OK)
                        scr = SCR_TIMER;
                    else if (key == KEY_LEFT)
                        fld = 2'((int'(fld) + 2) % 3);
                    else if (key == KEY_RIGHT)
                        fld = 2'((int'(fld) + 1) % 3);
                    else if (key == KEY_UP)
                        adjust(1'b1);
                    else if (key == KEY_DOWN)
                        adjust(1'b0);
                default: ;
            endcase
        endfunction

        function void take_input(press_word_t w);
            out_word_t        want;
            logic             alarm;
            logic             stop;
            longint unsigned  secs;
            alarm = 1'b0;
            stop  = 1'b0;
            if (w.mode == MODE_TICK)
                tick(alarm);
            else if (w.kind == PRESS_SHORT || w.kind == PRESS_REPEAT)
                press(w.key, alarm, stop);
            secs = (64'(rem) + rate() - 1) / rate();
            if (secs > SECS_MAX)
                secs = SECS_MAX;
            want                   = '0;
            want.screen            = scr;
            want.selected_row      = row;
            want.edit_field        = fld;
            want.stopwatch_count   = sw_cnt[31:0];
            want.stopwatch_active  = sw_on;
            want.timer_active      = tmr_on;
            want.remaining_seconds = SECS_BITS'(secs);
            want.duration_seconds  = dur;
            want.alarm_start       = alarm;
            want.alarm_stop        = stop;
            want.quit              = quit;
            due_readouts.push_back(want);
        endfunction

        function void compare(string label, logic [31:0] want, logic [31:0] got);
            if (got !== want)
            begin
                $error("%s: expected %0d, got %0d", label, want, got);
                errors++;
            end
        endfunction

        function void check_readout(out_word_t got);
            out_word_t want;
            if (due_readouts.size() == 0)
            begin
                $error("result word with nothing expected");
                errors++;
                return;
            end
            want = due_readouts.pop_front();
            compare("screen", want.screen, got.screen);
            compare("selected_row", want.selected_row, got.selected_row);
            compare("edit_field", want.edit_field, got.edit_field);
            compare("stopwatch_count", want.stopwatch_count, got.stopwatch_count);
            compare("stopwatch_active", want.stopwatch_active, got.stopwatch_active);
            compare("timer_active", want.timer_active, got.timer_active);
            compare("remaining_seconds", want.remaining_seconds, got.remaining_seconds);
            compare("duration_seconds", want.duration_seconds, got.duration_seconds);
            compare("alarm_start", want.alarm_start, got.alarm_start);
            compare("alarm_stop", want.alarm_stop, got.alarm_stop);
            compare("quit", want.quit, got.quit);
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = '0;
    logic        s_axis_tuser = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [79:0] m_axis_tdata;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic        cfg_index = 1'b0;
    logic [15:0] cfg_data = '0;

    timer_scoreboard board;
    bit              steady = 1'b0;
    int              readouts_seen = 0;

    stopwatch_countdown_timer_controller uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #5 clk = ~clk;

    task automatic push_word(logic mode, logic [2:0] key, logic [1:0] kind);
        press_word_t w;
        w = '{mode, key, kind};
        while (!steady && $urandom_range(0, 99) < 6)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= mode;
        s_axis_tdata  <= {3'b000, kind, key};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        board.take_input(w);
    endtask

    task automatic cfg_reg(logic idx, logic [15:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        board.set_reg(idx, val);
    endtask

    task automatic write_settings(logic [15:0] rate_val, logic [15:0] welcome_val);
        cfg_reg(CFG_TPS, rate_val);
        cfg_reg(CFG_WELCOME, welcome_val);
        cfg_valid <= 1'b0;
    endtask

    task automatic settle(int extra);
        s_axis_tvalid <= 1'b0;
        while (board.due_readouts.size() != 0)
            @(posedge clk);
        repeat (extra) @(posedge clk);
    endtask

    // steer edits toward short durations so the countdown expires often
    function automatic logic [2:0] shrink_key();
        int unsigned v, wrap;
        if (board.dur <= $urandom_range(1, 20))
            return KEY_OK;
        case (board.fld)
            FLD_HOURS:
            begin
                v    = board.dur / 3600;
                wrap = 24;
            end
            FLD_MINS:
            begin
                v    = (board.dur / 60) % 60;
                wrap = 60;
            end
            default:
            begin
                v    = board.dur % 60;
                wrap = 60;
            end
        endcase
        if (v == 0)
            return ($urandom_range(0, 3) == 0) ? KEY_LEFT : KEY_RIGHT;
        return (2 * v >= wrap) ? KEY_UP : KEY_DOWN;
    endfunction

    function automatic logic [2:0] steer_key();
        int unsigned r;
        r = $urandom_range(0, 99);
        case (board.scr)
            SCR_HOME:
                if (r < 45) return KEY_OK;
                else if (r < 80) return $urandom_range(0, 1) ? KEY_UP : KEY_DOWN;
                else if (r < 85) return KEY_BACK;
            SCR_WATCH:
                if (r < 50) return KEY_OK;
                else if (r < 65) return KEY_RIGHT;
                else if (r < 85) return KEY_BACK;
            SCR_TIMER:
                if (r < 45) return KEY_OK;
                else if (r < 55) return KEY_LEFT;
                else if (r < 75) return KEY_RIGHT;
                else if (r < 90) return KEY_BACK;
            SCR_EDIT:
                if (r < 60) return shrink_key();
                else if (r < 85) return 3'($urandom_range(0, 3));
                else return $urandom_range(0, 1) ? KEY_OK : KEY_BACK;
            SCR_DONE:
                if (r < 70) return $urandom_range(0, 1) ? KEY_OK : KEY_BACK;
            default: ;
        endcase
        return 3'($urandom_range(0, 5));
    endfunction

    task automatic run_random(int count);
        int unsigned roll;
        repeat (count)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 8)
                push_word(1'($urandom_range(0, 1)), 3'($urandom_range(0, 7)),
                          2'($urandom_range(0, 3)));
            else if (roll < 55)
                push_word(MODE_TICK, 3'($urandom_range(0, 7)), 2'($urandom_range(0, 3)));
            else
                push_word(MODE_KEY, steer_key(), 2'($urandom_range(0, 1)));
        end
    endtask

    initial
    begin
        logic [15:0] rate_val;
        logic [15:0] welcome_val;
        board = new();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_settings(16'(RATE_RESET), 16'd3);
        push_word(MODE_TICK, KEY_UP, PRESS_SHORT);
        push_word(MODE_KEY, KEY_UP, PRESS_OTHER);
        push_word(MODE_KEY, KEY_OK, PRESS_SPARE);
        push_word(MODE_TICK, KEY_UP, PRESS_SHORT);
        if ($urandom_range(0, 1))
            push_word(MODE_KEY, KEY_DOWN, PRESS_REPEAT);
        else
            push_word(MODE_TICK, KEY_SPARE, PRESS_SPARE);
        push_word(MODE_KEY, KEY_SPARE, PRESS_SHORT);
        push_word(MODE_KEY, KEY_BACK, PRESS_SHORT);
        push_word(MODE_KEY, KEY_OK, PRESS_SHORT);
        push_word(MODE_KEY, KEY_OK, PRESS_SHORT);
        push_word(MODE_TICK, KEY_UP, PRESS_SHORT);
        push_word(MODE_KEY, KEY_RIGHT, PRESS_SHORT);
        push_word(MODE_KEY, KEY_BACK, PRESS_SHORT);
        push_word(MODE_KEY, KEY_DOWN, PRESS_REPEAT);
        push_word(MODE_KEY, KEY_OK, PRESS_SHORT);
        push_word(MODE_KEY, KEY_RIGHT, PRESS_SHORT);
        push_word(MODE_KEY, KEY_DOWN, PRESS_SHORT);
        push_word(MODE_KEY, KEY_UP, PRESS_REPEAT);
        push_word(MODE_KEY, KEY_LEFT, PRESS_SHORT);
        push_word(MODE_KEY, KEY_OK, PRESS_SHORT);
        settle(8);

        // rate drops while 300 s are loaded: remaining seconds saturate
        write_settings(16'd1, 16'd0);
        push_word(MODE_KEY, KEY_RIGHT, PRESS_SHORT);
        push_word(MODE_KEY, KEY_RIGHT, PRESS_SHORT);
        repeat (5) push_word(MODE_KEY, KEY_DOWN, PRESS_SHORT);
        push_word(MODE_KEY, KEY_OK, PRESS_SHORT);
        push_word(MODE_KEY, KEY_OK, PRESS_SHORT);
        push_word(MODE_TICK, KEY_UP, PRESS_SHORT);
        push_word(MODE_KEY, KEY_BACK, PRESS_SHORT);
        push_word(MODE_KEY, KEY_OK, PRESS_SHORT);
        push_word(MODE_KEY, KEY_BACK, PRESS_SHORT);
        push_word(MODE_TICK, KEY_UP, PRESS_SHORT);
        push_word(MODE_KEY, KEY_OK, PRESS_SHORT);
        settle(8);

        for (int p = 0; p < 7; p++)
        begin
            welcome_val = 16'($urandom_range(0, 65535));
            case (p)
                0: begin rate_val = 16'd0;    welcome_val = 16'd0; end
                1: begin rate_val = 16'd1000; welcome_val = 16'hFFFF; end
                2: rate_val = 16'd2;
                3: begin rate_val = 16'd1023; welcome_val = WELC_RESET; end
                4: rate_val = 16'($urandom_range(1, 10));
                5: rate_val = 16'd1;
                default: rate_val = 16'($urandom_range(0, 65535));
            endcase
            write_settings(rate_val, welcome_val);
            steady = (p == 2);
            run_random(200);
            settle(8);
            steady = 1'b0;
        end

        settle(120);
        if (board.errors == 0 && board.due_readouts.size() == 0)
            $display("stopwatch_countdown_timer_controller test passed");
        else
            $display("stopwatch_countdown_timer_controller test failed");
        $finish;
    end

    // result side: random stalls plus one long hold to back the block up
    initial
    begin
        int  hold_left;
        bit  held;
        hold_left = 0;
        held      = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n)
            begin
                if (m_axis_tvalid && m_axis_tready)
                begin
                    board.check_readout(out_word_t'(m_axis_tdata));
                    readouts_seen++;
                end
                if (hold_left != 0)
                begin
                    hold_left--;
                    m_axis_tready <= 1'b0;
                end
                else if (readouts_seen == HOLD_AT && !held)
                begin
                    held      = 1'b1;
                    hold_left = HOLD_CYCLES;
                    m_axis_tready <= 1'b0;
                end
                else
                    m_axis_tready <= steady || ($urandom_range(0, 99) >= 6);
            end
        end
    end

    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                || (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("stopwatch_countdown_timer_controller test failed");
        $finish;
    end
endmodule
